// ===== src/max_distance_slot_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the max-distance slot allocator
// Concurrent checks clocked on clock, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef MAX_DISTANCE_SLOT_ALLOCATOR_ASSERT_SVH
`define MAX_DISTANCE_SLOT_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MDSA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MDSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mdsa_pkg.sv =====
// ---------------------------------------------------------------------------
// mdsa_pkg
// Shared types and codes of the max-distance slot allocator.
// ---------------------------------------------------------------------------
package mdsa_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_REL_CHK,
      ST_DONE
   } mdsa_state_type;

   // Request modes
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_REL = 2'd2;

   // Field and register widths
   localparam int SLOT_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int SEAT_COUNT_W = 9;
   localparam int PADDR_W      = 3;
   localparam int PDATA_W      = 32;

   // Register map (word index taken from paddr[2])
   localparam logic CSR_IDX_SEAT_COUNT = 1'b0;
   localparam logic [SEAT_COUNT_W-1:0] SEAT_COUNT_RESET = 9'd256;

endpackage

// ===== src/max_distance_slot_allocator.sv =====
// ---------------------------------------------------------------------------
// max_distance_slot_allocator
// Keeps a slot occupancy map; allocate takes the free slot farthest from
// its nearest taken neighbor (lowest index on ties), release frees a slot.
// ---------------------------------------------------------------------------
//  channel  handshake            payload                          direction
//  req      req_valid/req_ready  req_mode, req_position           in
//  rsp      rsp_valid/rsp_ready  rsp_chosen_slot, rsp_status      out
//  csr      psel/penable/pready  pwrite, paddr, pwdata, prdata    APB, seat_count at 0x0
//
//  Allocate: one map read per slot 0..n-1, n being seat_count clamped to
//  1..MAX_SLOTS, through the shared gap subtractor, then drain, pick,
//  finish; scan and drain are skipped when no slot is taken at all.
//  Release: map read, then update; both are skipped when the position
//  is at or beyond n. After reset a clearing pass over all MAX_SLOTS slots
//  runs with req_ready low; req_ready is high only while idle, and a result
//  held by rsp_ready stalls the next finishing step, not the accept.
// ---------------------------------------------------------------------------
`include "max_distance_slot_allocator_assert.svh"

module max_distance_slot_allocator #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [mdsa_pkg::SLOT_W-1:0]         req_position,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mdsa_pkg::SLOT_W-1:0]         rsp_chosen_slot,
   output logic [mdsa_pkg::STATUS_W-1:0]       rsp_status,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mdsa_pkg::PADDR_W-1:0]        paddr,
   input  logic [mdsa_pkg::PDATA_W-1:0]        pwdata,
   output logic [mdsa_pkg::PDATA_W-1:0]        prdata,
   output logic                                pready
);

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int LW = (CW > mdsa_pkg::SEAT_COUNT_W) ? CW : mdsa_pkg::SEAT_COUNT_W;

   // ---------------- registers ----------------
   mdsa_pkg::mdsa_state_type state_ff, state_in;
   logic [mdsa_pkg::SEAT_COUNT_W-1:0] seat_count_ff, seat_count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                n_ff, n_in;
   logic [CW-1:0]                total_ff, total_in;
   logic [mdsa_pkg::SLOT_W-1:0]  pos_ff, pos_in;
   logic                         rd_data_ff;
   logic                         rd_vld_ff, rd_vld_in;
   logic [IW-1:0]                rd_idx_ff, rd_idx_in;
   logic                         have_last_ff, have_last_in;
   logic [IW-1:0]                last_ff, last_in;
   logic                         have_best_ff, have_best_in;
   logic [IW-1:0]                best_pos_ff, best_pos_in;
   logic [IW-1:0]                best_dist_ff, best_dist_in;
   logic [mdsa_pkg::SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [mdsa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic                         wr_val_ff, wr_val_in;
   logic [IW-1:0]                wr_addr_ff, wr_addr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mdsa_pkg::SLOT_W-1:0]  rsp_chosen_slot_ff, rsp_chosen_slot_in;
   logic [mdsa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // occupancy memory, one bit per slot
   logic occ_mem [MAX_SLOTS];

   // ---------------- combinational signals ----------------
   logic          req_fire;
   logic          rsp_free;
   logic          csr_wr;
   logic          csr_idx;
   logic [LW-1:0] seat_wide;
   logic [LW-1:0] n_lim_wide;
   logic [LW-1:0] req_pos_wide;
   logic [LW-1:0] pos_ff_wide;
   logic          req_pos_bad;
   logic [CW-1:0] n_last;
   logic          scan_end;
   logic          hit;
   logic [IW-1:0] sub_a;
   logic [IW-1:0] sub_diff;
   logic [IW-1:0] gap_half;
   logic          tail_open;
   logic          tail_take;
   logic [IW-1:0] fin_pos;
   logic          fin_have;
   logic [LW-1:0] fin_pos_wide;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic          mem_wdata;
   logic [IW-1:0] mem_raddr;
   logic          done_fire;
   logic          done_alloc;

   // handshakes and config decode
   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign csr_idx  = paddr[2];
   assign csr_wr   = psel && penable && pwrite && pready;

   // clamp slot count to 1..MAX_SLOTS
   assign seat_wide  = LW'(seat_count_ff);
   assign n_lim_wide = (seat_wide == '0) ? LW'(1) :
                       (seat_wide > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : seat_wide;

   assign req_pos_wide = LW'(req_position);
   assign pos_ff_wide  = LW'(pos_ff);
   assign req_pos_bad  = req_pos_wide >= n_lim_wide;

   assign n_last   = n_ff - CW'(1);
   assign scan_end = idx_ff == n_last;
   assign hit      = rd_vld_ff && rd_data_ff;

   // shared gap subtractor: scan gap during the sweep, tail gap at the pick
   assign sub_a    = (state_ff == mdsa_pkg::ST_PICK) ? n_last[IW-1:0] : rd_idx_ff;
   assign sub_diff = sub_a - last_ff;
   assign gap_half = sub_diff >> 1;

   // final choice including the tail slot
   assign tail_open    = last_ff != n_last[IW-1:0];
   assign tail_take    = tail_open && (!have_best_ff || (sub_diff > best_dist_ff));
   assign fin_pos      = tail_take ? n_last[IW-1:0] : best_pos_ff;
   assign fin_have     = have_best_ff || tail_take;
   assign fin_pos_wide = LW'(fin_pos);

   assign done_fire  = (state_ff == mdsa_pkg::ST_DONE) && rsp_free;
   assign done_alloc = done_fire && wr_pend_ff && wr_val_ff;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mdsa_pkg::ST_CLEAR: begin
            if (idx_ff == CW'(MAX_SLOTS - 1)) state_in = mdsa_pkg::ST_IDLE;
         end
         mdsa_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == mdsa_pkg::MODE_RELEASE) begin
                  state_in = req_pos_bad ? mdsa_pkg::ST_DONE : mdsa_pkg::ST_REL_CHK;
               end else begin
                  state_in = (total_ff == '0) ? mdsa_pkg::ST_PICK : mdsa_pkg::ST_SCAN;
               end
            end
         end
         mdsa_pkg::ST_SCAN: begin
            if (scan_end) state_in = mdsa_pkg::ST_DRAIN;
         end
         mdsa_pkg::ST_DRAIN:   state_in = mdsa_pkg::ST_PICK;
         mdsa_pkg::ST_PICK:    state_in = mdsa_pkg::ST_DONE;
         mdsa_pkg::ST_REL_CHK: state_in = mdsa_pkg::ST_DONE;
         mdsa_pkg::ST_DONE: begin
            if (rsp_free) state_in = mdsa_pkg::ST_IDLE;
         end
         default: state_in = mdsa_pkg::ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IW-1:0];
      mem_wdata = 1'b0;
      mem_raddr = idx_ff[IW-1:0];
      case (state_ff)
         mdsa_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
         end
         mdsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mem_raddr = req_pos_wide[IW-1:0];
         end
         mdsa_pkg::ST_DONE: begin
            mem_we    = rsp_free && wr_pend_ff;
            mem_waddr = wr_addr_ff;
            mem_wdata = wr_val_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      seat_count_in      = seat_count_ff;
      idx_in             = idx_ff;
      n_in               = n_ff;
      total_in           = total_ff;
      pos_in             = pos_ff;
      rd_vld_in          = (state_ff == mdsa_pkg::ST_SCAN);
      rd_idx_in          = idx_ff[IW-1:0];
      have_last_in       = have_last_ff;
      last_in            = last_ff;
      have_best_in       = have_best_ff;
      best_pos_in        = best_pos_ff;
      best_dist_in       = best_dist_ff;
      res_slot_in        = res_slot_ff;
      res_status_in      = res_status_ff;
      wr_pend_in         = wr_pend_ff;
      wr_val_in          = wr_val_ff;
      wr_addr_in         = wr_addr_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_chosen_slot_in = rsp_chosen_slot_ff;
      rsp_status_in      = rsp_status_ff;

      // config write
      if (csr_wr && (csr_idx == mdsa_pkg::CSR_IDX_SEAT_COUNT)) begin
         seat_count_in = pwdata[mdsa_pkg::SEAT_COUNT_W-1:0];
      end

      case (state_ff)
         mdsa_pkg::ST_CLEAR: begin
            idx_in = idx_ff + CW'(1);
         end
         mdsa_pkg::ST_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               pos_in       = req_position;
               n_in         = n_lim_wide[CW-1:0];
               have_last_in = 1'b0;
               last_in      = '0;
               have_best_in = 1'b0;
               best_pos_in  = '0;
               best_dist_in = '0;
               wr_pend_in   = 1'b0;
               res_slot_in  = req_position;
               res_status_in = mdsa_pkg::STATUS_BAD_REL;
            end
         end
         mdsa_pkg::ST_SCAN, mdsa_pkg::ST_DRAIN: begin
            if (state_ff == mdsa_pkg::ST_SCAN) idx_in = idx_ff + CW'(1);
            // fold one taken slot into the running widest gap
            if (hit) begin
               if (!have_last_ff) begin
                  if (rd_idx_ff != '0) begin
                     best_pos_in  = '0;
                     best_dist_in = rd_idx_ff;
                     have_best_in = 1'b1;
                  end
               end else if (sub_diff > IW'(1)) begin
                  if (!have_best_ff || (gap_half > best_dist_ff)) begin
                     best_pos_in  = last_ff + gap_half;
                     best_dist_in = gap_half;
                     have_best_in = 1'b1;
                  end
               end
               last_in      = rd_idx_ff;
               have_last_in = 1'b1;
            end
         end
         mdsa_pkg::ST_PICK: begin
            if (!have_last_ff) begin
               // nothing taken in range: slot 0
               res_slot_in   = '0;
               res_status_in = mdsa_pkg::STATUS_OK;
               wr_pend_in    = 1'b1;
               wr_val_in     = 1'b1;
               wr_addr_in    = '0;
            end else if (fin_have) begin
               res_slot_in   = fin_pos_wide[mdsa_pkg::SLOT_W-1:0];
               res_status_in = mdsa_pkg::STATUS_OK;
               wr_pend_in    = 1'b1;
               wr_val_in     = 1'b1;
               wr_addr_in    = fin_pos;
            end else begin
               res_slot_in   = '0;
               res_status_in = mdsa_pkg::STATUS_FULL;
               wr_pend_in    = 1'b0;
            end
         end
         mdsa_pkg::ST_REL_CHK: begin
            res_slot_in = pos_ff;
            wr_addr_in  = pos_ff_wide[IW-1:0];
            wr_val_in   = 1'b0;
            if (rd_data_ff) begin
               res_status_in = mdsa_pkg::STATUS_OK;
               wr_pend_in    = 1'b1;
            end else begin
               res_status_in = mdsa_pkg::STATUS_BAD_REL;
               wr_pend_in    = 1'b0;
            end
         end
         mdsa_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_chosen_slot_in = res_slot_ff;
               rsp_status_in      = res_status_ff;
               if (wr_pend_ff) begin
                  total_in = wr_val_ff ? (total_ff + CW'(1)) : (total_ff - CW'(1));
               end
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mdsa_pkg::ST_CLEAR;
         seat_count_ff <= mdsa_pkg::SEAT_COUNT_RESET;
         idx_ff        <= '0;
         total_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seat_count_ff <= seat_count_in;
         idx_ff        <= idx_in;
         total_ff      <= total_in;
         rd_vld_ff     <= rd_vld_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      n_ff               <= n_in;
      pos_ff             <= pos_in;
      rd_idx_ff          <= rd_idx_in;
      have_last_ff       <= have_last_in;
      last_ff            <= last_in;
      have_best_ff       <= have_best_in;
      best_pos_ff        <= best_pos_in;
      best_dist_ff       <= best_dist_in;
      res_slot_ff        <= res_slot_in;
      res_status_ff      <= res_status_in;
      wr_val_ff          <= wr_val_in;
      wr_addr_ff         <= wr_addr_in;
      rsp_chosen_slot_ff <= rsp_chosen_slot_in;
      rsp_status_ff      <= rsp_status_in;
   end

   // ---------------- occupancy memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= occ_mem[mem_raddr];
   end

   // ---------------- ports ----------------
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_slot = rsp_chosen_slot_ff;
   assign rsp_status      = rsp_status_ff;
   assign pready          = 1'b1;
   assign prdata          = (csr_idx == mdsa_pkg::CSR_IDX_SEAT_COUNT) ?
                            {{(mdsa_pkg::PDATA_W - mdsa_pkg::SEAT_COUNT_W){1'b0}},
                             seat_count_ff} : '0;

   // ---------------- assertions ----------------
   `MDSA_ASSERT_SAME(a_scan_in_range, state_ff == mdsa_pkg::ST_SCAN,
                     idx_ff < n_ff, "scan index past slot count")
   `MDSA_ASSERT_NEXT(a_alloc_counts, done_alloc, total_ff == $past(total_ff) + CW'(1),
                     "taken count not bumped on allocate")
   `MDSA_ASSERT_NEXT(a_result_shown, done_fire,
                     rsp_valid_ff && (rsp_status_ff == $past(res_status_ff)),
                     "finished item not presented")

endmodule
